// ----- rtl/mexp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mexp_pkg: shared definitions for the modular exponentiation block
// Modulus and Barrett constants, widths, state types and the handshake
// structs between the exponent sequencer and the modular multiplier.
// ----------------------------------------------------------------------------
package mexp_pkg;

  localparam int unsigned ValW      = 30;
  localparam int unsigned ExpWidth  = 32;
  localparam int unsigned InTdataW  = 64;
  localparam int unsigned OutTdataW = 32;
  localparam int unsigned MulW      = 31;
  localparam int unsigned ProdW     = 2 * MulW;
  localparam int unsigned RemW      = 32;

  localparam logic [ValW-1:0] Modulus    = 30'd1000000007;
  localparam logic [RemW-1:0] ModulusX1  = 32'd1000000007;
  localparam logic [RemW-1:0] ModulusX2  = 32'd2000000014;
  // floor(2^60 / modulus)
  localparam logic [MulW-1:0] BarrettMu  = 31'd1152921496;
  localparam logic [ValW-1:0] ValOne     = 30'd1;

  typedef enum logic [1:0] {
    CT_IDLE,
    CT_STEP,
    CT_WMUL,
    CT_WSQ
  } ctl_state_e;

  typedef enum logic [2:0] {
    MM_IDLE,
    MM_QEST,
    MM_QMUL,
    MM_SUB,
    MM_FIX
  } mm_state_e;

  typedef struct packed {
    logic            start;
    logic [ValW-1:0] op_a;
    logic [ValW-1:0] op_b;
  } mm_req_t;

  typedef struct packed {
    logic            done;
    logic [ValW-1:0] result;
  } mm_rsp_t;

endpackage

// ----- rtl/mexp_modmul.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mexp_modmul: modular multiplier with Barrett reduction
// One registered 31x31 multiplier is reused three times per product:
// a*b, quotient estimate, quotient times modulus; then subtract and fix.
// ----------------------------------------------------------------------------
module mexp_modmul (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mexp_pkg::mm_req_t req_i,
  output mexp_pkg::mm_rsp_t rsp_o
);

  mexp_pkg::mm_state_e state_q, state_d;

  logic [mexp_pkg::MulW-1:0]  mul_a, mul_b;
  logic [mexp_pkg::ProdW-1:0] prod_q, prod_d;
  logic [mexp_pkg::RemW-1:0]  xlo_q, xlo_d;
  logic [mexp_pkg::RemW-1:0]  rem_q, rem_d;
  logic [mexp_pkg::ValW-1:0]  res_q, res_d;
  logic                       done_q, done_d;

  assign prod_d = mul_a * mul_b;

  always_comb begin
    state_d = state_q;
    mul_a   = {1'b0, req_i.op_a};
    mul_b   = {1'b0, req_i.op_b};
    xlo_d   = xlo_q;
    rem_d   = rem_q;
    res_d   = res_q;
    done_d  = 1'b0;
    case (state_q)
      mexp_pkg::MM_IDLE: begin
        if (req_i.start) begin
          state_d = mexp_pkg::MM_QEST;
        end
      end
      mexp_pkg::MM_QEST: begin
        // (x >> 29) * mu
        mul_a   = prod_q[59:29];
        mul_b   = mexp_pkg::BarrettMu;
        xlo_d   = prod_q[mexp_pkg::RemW-1:0];
        state_d = mexp_pkg::MM_QMUL;
      end
      mexp_pkg::MM_QMUL: begin
        mul_a   = prod_q[61:31];
        mul_b   = {1'b0, mexp_pkg::Modulus};
        state_d = mexp_pkg::MM_SUB;
      end
      mexp_pkg::MM_SUB: begin
        // true remainder is below 3p < 2^32, so low bits suffice
        rem_d   = xlo_q - prod_q[mexp_pkg::RemW-1:0];
        state_d = mexp_pkg::MM_FIX;
      end
      mexp_pkg::MM_FIX: begin
        if (rem_q >= mexp_pkg::ModulusX2) begin
          res_d = mexp_pkg::ValW'(rem_q - mexp_pkg::ModulusX2);
        end else if (rem_q >= mexp_pkg::ModulusX1) begin
          res_d = mexp_pkg::ValW'(rem_q - mexp_pkg::ModulusX1);
        end else begin
          res_d = mexp_pkg::ValW'(rem_q);
        end
        done_d  = 1'b1;
        state_d = mexp_pkg::MM_IDLE;
      end
      default: begin
        state_d = mexp_pkg::MM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mexp_pkg::MM_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    xlo_q  <= xlo_d;
    rem_q  <= rem_d;
    res_q  <= res_d;
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.result = res_q;

endmodule

// ----- rtl/modular_exponentiation.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modular_exponentiation: base^exponent mod 1000000007
// Right-to-left square and multiply over a shared Barrett modular multiplier.
//
// Usage:
//   Slave stream: one beat carries base_value and exponent. tready is high
//   only while the sequencer is idle; one beat is in flight at a time.
//   Master stream: one beat per input beat with power_result.
//   Each modular product runs on the shared multiplier. Per exponent bit
//   up to the highest set bit the sequencer squares, and first multiplies
//   the accumulator by the square when the bit is set.
//   A zero exponent returns 1.
//   The result sits in an output register; the next input beat is taken
//   while it waits. If the receiver stalls, the finished next result waits
//   in the sequencer until the output register frees.
//   Reset clears the sequencer and the output valid; no state is kept
//   between beats.
// ----------------------------------------------------------------------------
module modular_exponentiation #(
  parameter int unsigned EXP_WIDTH = mexp_pkg::ExpWidth
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // [29:0] base_value, [61:30] exponent, [63:62] zero
  input  logic [mexp_pkg::InTdataW-1:0]     s_axis_tdata_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // [29:0] power_result, [31:30] zero
  output logic [mexp_pkg::OutTdataW-1:0]    m_axis_tdata_o
);

  localparam int unsigned ValW = mexp_pkg::ValW;

  mexp_pkg::ctl_state_e state_q, state_d;

  logic [ValW-1:0]      sq_q, sq_d;
  logic [ValW-1:0]      acc_q, acc_d;
  logic [EXP_WIDTH-1:0] exp_q, exp_d;
  logic                 out_valid_q, out_valid_d;
  logic [ValW-1:0]      out_data_q, out_data_d;
  logic [ValW-1:0]      in_base;
  logic [31:0]          in_exp;

  mexp_pkg::mm_req_t mm_req;
  mexp_pkg::mm_rsp_t mm_rsp;

  assign in_base = s_axis_tdata_i[29:0];
  assign in_exp  = s_axis_tdata_i[61:30];

  mexp_modmul u_modmul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mm_req),
    .rsp_o  (mm_rsp)
  );

  always_comb begin
    state_d         = state_q;
    sq_d            = sq_q;
    acc_d           = acc_q;
    exp_d           = exp_q;
    out_valid_d     = out_valid_q;
    out_data_d      = out_data_q;
    mm_req          = '0;
    s_axis_tready_o = 1'b0;
    if (out_valid_q && m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      mexp_pkg::CT_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (s_axis_tvalid_i) begin
          sq_d    = (in_base >= mexp_pkg::Modulus) ? in_base - mexp_pkg::Modulus : in_base;
          exp_d   = EXP_WIDTH'(in_exp);
          acc_d   = mexp_pkg::ValOne;
          state_d = mexp_pkg::CT_STEP;
        end
      end
      mexp_pkg::CT_STEP: begin
        if (exp_q == '0) begin
          if (!out_valid_q || m_axis_tready_i) begin
            out_valid_d = 1'b1;
            out_data_d  = acc_q;
            state_d     = mexp_pkg::CT_IDLE;
          end
        end else if (exp_q[0]) begin
          mm_req.start = 1'b1;
          mm_req.op_a  = acc_q;
          mm_req.op_b  = sq_q;
          state_d      = mexp_pkg::CT_WMUL;
        end else begin
          mm_req.start = 1'b1;
          mm_req.op_a  = sq_q;
          mm_req.op_b  = sq_q;
          state_d      = mexp_pkg::CT_WSQ;
        end
      end
      mexp_pkg::CT_WMUL: begin
        if (mm_rsp.done) begin
          acc_d        = mm_rsp.result;
          mm_req.start = 1'b1;
          mm_req.op_a  = sq_q;
          mm_req.op_b  = sq_q;
          state_d      = mexp_pkg::CT_WSQ;
        end
      end
      mexp_pkg::CT_WSQ: begin
        if (mm_rsp.done) begin
          sq_d    = mm_rsp.result;
          exp_d   = exp_q >> 1;
          state_d = mexp_pkg::CT_STEP;
        end
      end
      default: begin
        state_d = mexp_pkg::CT_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mexp_pkg::CT_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sq_q       <= sq_d;
    acc_q      <= acc_d;
    exp_q      <= exp_d;
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {2'b00, out_data_q};

endmodule

// ----- rtl/mexp_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mexp_checker: port-level checks for modular_exponentiation
// Watches both stream sides; bound to the top level below.
// ----------------------------------------------------------------------------
module mexp_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid_i,
  input logic                           s_axis_tready_o,
  input logic [mexp_pkg::InTdataW-1:0]  s_axis_tdata_i,
  input logic                           m_axis_tvalid_o,
  input logic                           m_axis_tready_i,
  input logic [mexp_pkg::OutTdataW-1:0] m_axis_tdata_o
);

  logic s_beat;

  assign s_beat = s_axis_tvalid_i && s_axis_tready_o;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("output valid dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o))
    else $error("output data changed while stalled");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_beat |=> !s_axis_tready_o)
    else $error("input taken while a beat is in flight");

  a_result_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o < 32'd1000000007))
    else $error("result not reduced");

  a_out_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(!s_axis_tready_o))
    else $error("result without a beat at work");

endmodule

bind modular_exponentiation mexp_checker u_mexp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tdata_i  (s_axis_tdata_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

// ----- tb/sv/modular_exponentiation_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modular_exponentiation_tb: self-checking bench for base^exp mod 1000000007
// Streams operand beats through the block under three backpressure phases
// and checks every power result, in order, against a square-and-multiply
// model kept inside the bench. Directed corner operands come first, then
// random operands with a mix of short, sparse and full-width exponents.
// ----------------------------------------------------------------------------
module modular_exponentiation_tb;

  localparam int unsigned     ExpW       = 32;
  localparam longint unsigned PrimeMod   = 64'd1000000007;
  localparam logic [29:0]     BaseTop    = 30'd1000000006;
  localparam logic [29:0]     BaseAllOne = 30'h3FFF_FFFF;
  localparam int              StallLimit = 5000;
  localparam int              DrainWait  = 400;
  localparam int              PhaseItems = 511;

  typedef struct packed {
    logic [31:0] exponent;
    logic [29:0] base_value;
  } operands_t;

  typedef struct packed {
    logic [31:0] exponent;
    logic [29:0] base_value;
    logic [29:0] power;
  } power_exp_t;

  logic                           clk_i           = 1'b0;
  logic                           rst_ni          = 1'b0;
  logic                           s_axis_tvalid_i = 1'b0;
  logic                           s_axis_tready_o;
  logic [mexp_pkg::InTdataW-1:0]  s_axis_tdata_i  = '0;
  logic                           m_axis_tvalid_o;
  logic                           m_axis_tready_i = 1'b0;
  logic [mexp_pkg::OutTdataW-1:0] m_axis_tdata_o;

  operands_t  pending_ops[$];
  power_exp_t expected_powers[$];

  int send_idle_pct = 35;
  int recv_idle_pct = 85;
  int mismatch_cnt  = 0;
  int beats_in      = 0;
  int beats_out     = 0;
  int quiet_cycles  = 0;

  modular_exponentiation #(
    .EXP_WIDTH(ExpW)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic logic [29:0] mod_power(input logic [29:0] base_value,
                                            input logic [31:0] exponent);
    longint unsigned sq;
    longint unsigned acc;
    sq  = longint'(base_value) % PrimeMod;
    acc = 1;
    for (int i = 0; i < ExpW; i++) begin
      if (exponent[i]) acc = (acc * sq) % PrimeMod;
      sq = (sq * sq) % PrimeMod;
    end
    return acc[29:0];
  endfunction

  task automatic queue_ops(input logic [29:0] base_value, input logic [31:0] exponent);
    operands_t op;
    op.base_value = base_value;
    op.exponent   = exponent;
    pending_ops.insert(pending_ops.size(), op);
  endtask

  task automatic queue_random_ops(input int count);
    logic [29:0] b;
    logic [31:0] e;
    int          pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 75) b = 30'($urandom_range(0, 1000000006));
      else if (pick < 88) b = 30'($urandom_range(1000000007, 32'h3FFF_FFFF));
      else b = 30'($urandom_range(0, 15));
      pick = $urandom_range(99);
      if (pick < 40) e = $urandom;
      else if (pick < 70) e = $urandom_range(0, 255);
      else if (pick < 85) e = 32'd1 << $urandom_range(0, 31);
      else e = $urandom & $urandom & $urandom;
      queue_ops(b, e);
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_ops.size() != 0 || s_axis_tvalid_i || expected_powers.size() != 0);
  endtask

  // operand driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
      s_axis_tdata_i  <= '0;
    end else if (!s_axis_tvalid_i || s_axis_tready_o) begin
      if (pending_ops.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        s_axis_tvalid_i <= 1'b1;
        s_axis_tdata_i  <= {2'b00, pending_ops.pop_front()};
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
  end

  // result backpressure
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // monitor, checker and watchdog
  always @(posedge clk_i) begin
    power_exp_t exp_beat;
    power_exp_t got;
    logic       moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        got.base_value = s_axis_tdata_i[29:0];
        got.exponent   = s_axis_tdata_i[61:30];
        got.power      = mod_power(got.base_value, got.exponent);
        expected_powers.insert(expected_powers.size(), got);
        beats_in++;
        moved = 1'b1;
      end
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        beats_out++;
        moved = 1'b1;
        if (expected_powers.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, actual %0d",
                   $time, m_axis_tdata_o[29:0]);
          mismatch_cnt++;
        end else begin
          exp_beat = expected_powers.pop_front();
          if (m_axis_tdata_o[29:0] !== exp_beat.power) begin
            $display("%0t: power_result mismatch (base %0d, exp 'h%08h) expected %0d actual %0d",
                     $time, exp_beat.base_value, exp_beat.exponent, exp_beat.power,
                     m_axis_tdata_o[29:0]);
            mismatch_cnt++;
          end
        end
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("%0t: watchdog expired, %0d results outstanding",
                 $time, expected_powers.size());
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // corner operands
    queue_ops(30'd0, 32'd0);
    queue_ops(30'd0, 32'd1);
    queue_ops(30'd0, 32'hFFFF_FFFF);
    queue_ops(30'd1, 32'hFFFF_FFFF);
    queue_ops(BaseTop, 32'd0);
    queue_ops(BaseTop, 32'd1);
    queue_ops(BaseTop, 32'd2);
    queue_ops(BaseTop, 32'hFFFF_FFFF);
    queue_ops(BaseAllOne, 32'd0);
    queue_ops(BaseAllOne, 32'd1);
    queue_ops(BaseAllOne, 32'hFFFF_FFFF);
    queue_ops(30'd1000000007, 32'd1);
    queue_ops(30'd1000000008, 32'd5);
    queue_ops(30'd2, 32'd31);
    queue_ops(30'd2, 32'h8000_0000);
    queue_ops(30'd123456789, 32'd1000000006);
    queue_ops(30'h2AAA_AAAA, 32'h5555_5555);
    queue_ops(30'h1555_5555, 32'hAAAA_AAAA);
    queue_random_ops(PhaseItems);
    wait_drained();

    send_idle_pct = 85;
    recv_idle_pct = 35;
    queue_random_ops(PhaseItems);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random_ops(PhaseItems);
    wait_drained();

    repeat (DrainWait) @(negedge clk_i);
    if (expected_powers.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, expected_powers.size());
      mismatch_cnt++;
    end
    $display("Sent %0d operand beats, checked %0d power results over three stall phases",
             beats_in, beats_out);
    $display("Corners covered: zero exponent, zero base, bases at and above the modulus");
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
